// ===== sv/lurf_pkg.sv =====
// Package for the largest usable region finder: table sizing, command and
// response payload types, the operation codes and the sequencer states.
// No dependencies; every other file imports this package.
package lurf_pkg;

  // Table sizing.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  // Width used to compare a 6-bit request index against the entry count.
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  // Region kind that marks usable memory.
  localparam logic [31:0] USABLE_KIND = 32'd1;

  // Operation codes carried in the command.
  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_FIND = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLIP,
    ST_TRIM,
    ST_CMP,
    ST_FIN
  } state_t;

  // One command transfer.
  typedef struct packed {
    mode_t       mode;
    logic [63:0] entry_addr;
    logic [63:0] entry_len;
    logic [31:0] entry_kind;
    logic [63:0] lower_bound;
    logic [63:0] upper_bound;
    logic [5:0]  entry_index;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic        ok;
    logic [63:0] best_start;
    logic [63:0] best_end;
    logic [63:0] read_addr;
    logic [63:0] read_len;
    logic [31:0] read_kind;
    logic [5:0]  entry_total;
  } rsp_t;

  // One stored region.
  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] len;
    logic [31:0] kind;
  } entry_t;

endpackage

// ===== sv/largest_usable_region_finder_core.sv =====
// Top level of the largest usable region finder: region table memory and the
// sequencer that adds, reads and searches entries one step at a time.
// Depends on lurf_pkg for sizing, payload types, operation codes and states.
//
//   channel  | signals               | handshake
//   ---------+-----------------------+------------------------------------------
//   command  | start, busy, cmd      | transfer when start is high, busy is low
//   result   | done, result          | done high for one cycle, always taken
//
// Add and the unused operation give their result in the cycle after the
// command transfer and keep busy low. Read goes through one registered table
// read and then the read state. Find on an empty table answers in the cycle
// after the transfer; otherwise each entry passes through the clip, trim and
// compare steps, and its compare step issues the next entry's table read.
// Reset clears the sequencer, the entry count and the result strobe; the table
// contents stay undefined until written. The receiver cannot stall a result.
module largest_usable_region_finder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lurf_pkg::cmd_t cmd,
  output logic          done,
  output lurf_pkg::rsp_t result
);
  import lurf_pkg::*;

  // Region table storage and its ports.
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  entry_t mem_wdata;
  logic   mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  // Control state.
  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic done_next;

  // Working registers of the search and read steps.
  logic [IDX_W-1:0] idx, idx_next;
  logic [63:0] lo, lo_next;
  logic [63:0] hi, hi_next;
  logic [63:0] span_end, span_end_next;
  logic [63:0] span_base, span_base_next;
  logic        usable, usable_next;
  logic        skip, skip_next;
  logic [63:0] clip_end, clip_end_next;
  logic [63:0] best_start, best_start_next;
  logic [63:0] best_end, best_end_next;
  logic [63:0] best_len, best_len_next;
  logic        read_ok, read_ok_next;
  rsp_t        result_next;
  logic [63:0] span_len;

  assign busy = (state != ST_IDLE);

  // Table write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    lo         <= lo_next;
    hi         <= hi_next;
    span_end   <= span_end_next;
    span_base  <= span_base_next;
    usable     <= usable_next;
    skip       <= skip_next;
    clip_end   <= clip_end_next;
    best_start <= best_start_next;
    best_end   <= best_end_next;
    best_len   <= best_len_next;
    read_ok    <= read_ok_next;
    result     <= result_next;
  end

  // Length of the clipped span under evaluation.
  assign span_len = clip_end - span_base;

  // Sequencer: next state, datapath steps and table access.
  always_comb begin
    state_next      = state;
    count_next      = count;
    done_next       = 1'b0;
    idx_next        = idx;
    lo_next         = lo;
    hi_next         = hi;
    span_end_next   = span_end;
    span_base_next  = span_base;
    usable_next     = usable;
    skip_next       = skip;
    clip_end_next   = clip_end;
    best_start_next = best_start;
    best_end_next   = best_end;
    best_len_next   = best_len;
    read_ok_next    = read_ok;
    result_next     = result;
    mem_we          = 1'b0;
    mem_waddr       = count[IDX_W-1:0];
    mem_wdata       = '{addr: cmd.entry_addr, len: cmd.entry_len, kind: cmd.entry_kind};
    mem_raddr       = idx;

    case (state)
      ST_IDLE: begin
        if (start) begin
          result_next = '0;
          result_next.entry_total = 6'(count);
          case (cmd.mode)
            MODE_ADD: begin
              // Append while there is room; the result follows at once.
              if (count < CNT_W'(TABLE_DEPTH)) begin
                mem_we = 1'b1;
                count_next = count + CNT_W'(1);
                result_next.ok = 1'b1;
                result_next.entry_total = 6'(count + CNT_W'(1));
              end
              done_next = 1'b1;
            end
            MODE_FIND: begin
              // Latch the window, clear the best span and fetch entry zero.
              lo_next         = cmd.lower_bound;
              hi_next         = cmd.upper_bound;
              idx_next        = '0;
              best_start_next = '0;
              best_end_next   = '0;
              best_len_next   = '0;
              mem_raddr       = '0;
              if (count == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_CLIP;
              end
            end
            MODE_READ: begin
              mem_raddr    = cmd.entry_index[IDX_W-1:0];
              read_ok_next = CMP_W'(cmd.entry_index) < CMP_W'(count);
              state_next   = ST_READ;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        // Table data is ready; a bad index answers with zeros.
        result_next.ok = read_ok;
        if (read_ok) begin
          result_next.read_addr = rd_data.addr;
          result_next.read_len  = rd_data.len;
          result_next.read_kind = rd_data.kind;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_CLIP: begin
        // Region end (wrapping) and the start clipped to the lower bound.
        span_end_next  = rd_data.addr + rd_data.len;
        span_base_next = (rd_data.addr < lo) ? lo : rd_data.addr;
        usable_next    = (rd_data.kind == USABLE_KIND) && (rd_data.len != '0);
        state_next     = ST_TRIM;
      end

      ST_TRIM: begin
        // Drop unusable regions and those outside the window, and clip the end to the upper bound.
        skip_next = !usable || (span_end <= lo) || ((span_end > hi) && (span_base >= hi));
        clip_end_next = (span_end > hi) ? hi : span_end;
        state_next = ST_CMP;
      end

      ST_CMP: begin
        // Keep a strictly longer span; the first of equal spans stays.
        if (!skip && (best_len < span_len)) begin
          best_start_next = span_base;
          best_end_next   = clip_end;
          best_len_next   = span_len;
        end
        if (CNT_W'(idx) + CNT_W'(1) == count) begin
          state_next = ST_FIN;
        end else begin
          idx_next   = idx + IDX_W'(1);
          mem_raddr  = idx + IDX_W'(1);
          state_next = ST_CLIP;
        end
      end

      ST_FIN: begin
        // Success needs a nonempty span that does not start at zero.
        result_next.ok = (best_end > best_start) && (best_start != '0);
        result_next.best_start = best_start;
        result_next.best_end   = best_end;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
